>>> rtl/spd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

   localparam logic [7:0] HDR_BYTE_FF = 8'hFF;
   localparam logic [7:0] HDR_BYTE_FD = 8'hFD;
   localparam logic [7:0] HDR_BYTE_00 = 8'h00;

   // header, id and length bytes
   localparam logic [16:0] FRAME_OVERHEAD = 17'd7;
   // instruction byte plus the two crc bytes
   localparam logic [15:0] MIN_BODY_LENGTH = 16'd3;

   localparam logic [15:0] CRC_POLY = 16'h8005;
   localparam logic [15:0] MAX_PACKET_RESET = 16'd255;

   localparam logic [1:0] KIND_PARAM   = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_CRC_ERR = 2'd2;
   localparam logic [1:0] KIND_LEN_ERR = 2'd3;

   typedef enum logic [10:0] {
      PH_HUNT0 = 11'b000_0000_0001,
      PH_HUNT1 = 11'b000_0000_0010,
      PH_HUNT2 = 11'b000_0000_0100,
      PH_HUNT3 = 11'b000_0000_1000,
      PH_ID    = 11'b000_0001_0000,
      PH_LENLO = 11'b000_0010_0000,
      PH_LENHI = 11'b000_0100_0000,
      PH_INSTR = 11'b000_1000_0000,
      PH_PARAM = 11'b001_0000_0000,
      PH_CRCLO = 11'b010_0000_0000,
      PH_CRCHI = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  param_byte;
      logic [15:0] param_index;
      logic [7:0]  packet_id;
      logic [7:0]  instruction_code;
      logic [15:0] param_count;
   } result_type;

   // one byte through the msb-first crc-16, poly 0x8005
   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   localparam logic [15:0] HDR_CRC =
      crc_add(crc_add(crc_add(crc_add(16'h0000, HDR_BYTE_FF), HDR_BYTE_FF),
                      HDR_BYTE_FD), HDR_BYTE_00);

endpackage

`default_nettype wire

>>> rtl/servo_packet_deframer_crc16_unit.sv
// Packet deframer with CRC-16 (poly 0x8005, init 0) check.
// Input channel: one received byte per transaction on req_rx_byte, taken
// when req_valid is high and req_stall is low.
// Result channel: at most one transaction per input byte, rsp_result_kind
// 0 parameter byte, 1 packet good, 2 crc mismatch, 3 bad length, with the
// packet id, instruction, parameter index and parameter count alongside.
// csr_write_enable / csr_write_data load max_packet_bytes (whole packet,
// header through CRC); write only while the block is idle.
// An accepted byte waits in the input register, passes the combinational
// deframe/CRC step and loads the result register, which drives rsp_valid.
// Throughput: one byte per cycle while the receiver does not stall, set by
// the input register, the deframe/CRC step and the result register.
// Reset clears both stages, returns the hunt to the first header byte and
// sets max_packet_bytes to 255.
// When the receiver stalls, the result register holds; the next byte waits
// in the input register and req_stall rises only once that one is occupied.
`timescale 1ns / 1ps
`default_nettype none

module servo_packet_deframer_crc16_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_result_kind,
   output logic [7:0]       rsp_param_byte,
   output logic [15:0]      rsp_param_index,
   output logic [7:0]       rsp_packet_id,
   output logic [7:0]       rsp_instruction_code,
   output logic [15:0]      rsp_param_count
);
   import spd_pkg::*;

   logic       item_valid;
   logic [7:0] item_byte;
   logic       out_ready;
   logic       fire;
   logic       result_valid;
   logic       out_valid;
   result_type result;
   result_type rsp_result;

   assign fire = item_valid && out_ready;
   // the core decodes whatever byte is held; only a present byte yields a result
   assign out_valid = result_valid && item_valid;

   spd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .consume     (fire),
      .item_valid  (item_valid),
      .item_byte   (item_byte)
   );

   spd_deframe_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fire             (fire),
      .item_byte        (item_byte),
      .result_valid     (result_valid),
      .result           (result)
   );

   spd_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .result_valid (out_valid),
      .result       (result),
      .out_ready    (out_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_result   (rsp_result)
   );

   assign rsp_result_kind      = rsp_result.result_kind;
   assign rsp_param_byte       = rsp_result.param_byte;
   assign rsp_param_index      = rsp_result.param_index;
   assign rsp_packet_id        = rsp_result.packet_id;
   assign rsp_instruction_code = rsp_result.instruction_code;
   assign rsp_param_count      = rsp_result.param_count;

endmodule

`default_nettype wire

>>> rtl/spd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module spd_in_stage (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       consume,
   output logic            item_valid,
   output logic [7:0]      item_byte
);
   import spd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   // the held byte leaves in the same cycle a new one arrives
   assign req_stall = valid_ff && !consume;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

`default_nettype wire

>>> rtl/spd_deframe_core.sv
`timescale 1ns / 1ps
`default_nettype none

module spd_deframe_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [15:0]        csr_write_data,
   input  wire logic               fire,
   input  wire logic [7:0]         item_byte,
   output logic                    result_valid,
   output spd_pkg::result_type     result
);
   import spd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  instr_ff, instr_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [15:0] max_bytes_ff;

   logic [15:0] crc_next;
   logic [15:0] pcount;
   logic [15:0] new_length;
   logic [16:0] packet_bytes;

   assign crc_next     = crc_add(crc_ff, item_byte);
   assign pcount       = length_ff - MIN_BODY_LENGTH;
   assign new_length   = {item_byte, length_ff[7:0]};
   assign packet_bytes = {1'b0, new_length} + FRAME_OVERHEAD;

   always_comb begin
      phase_in     = phase_ff;
      id_in        = id_ff;
      length_in    = length_ff;
      count_in     = count_ff;
      instr_in     = instr_ff;
      crc_in       = crc_ff;
      crc_low_in   = crc_low_ff;
      result_valid = 1'b0;
      result       = '0;
      result.packet_id = id_ff;

      unique case (phase_ff)
         PH_HUNT1: begin
            phase_in = (item_byte == HDR_BYTE_FF) ? PH_HUNT2 : PH_HUNT0;
         end
         PH_HUNT2: begin
            if (item_byte == HDR_BYTE_FD) begin
               phase_in = PH_HUNT3;
            end else if (item_byte != HDR_BYTE_FF) begin
               phase_in = PH_HUNT0;
            end
         end
         PH_HUNT3: begin
            if (item_byte == HDR_BYTE_00) begin
               crc_in   = HDR_CRC;
               phase_in = PH_ID;
            end else begin
               phase_in = PH_HUNT0;
            end
         end
         PH_ID: begin
            id_in    = item_byte;
            crc_in   = crc_next;
            phase_in = PH_LENLO;
         end
         PH_LENLO: begin
            length_in = {8'h00, item_byte};
            crc_in    = crc_next;
            phase_in  = PH_LENHI;
         end
         PH_LENHI: begin
            length_in = new_length;
            crc_in    = crc_next;
            if (new_length < MIN_BODY_LENGTH ||
                packet_bytes > {1'b0, max_bytes_ff}) begin
               phase_in           = PH_HUNT0;
               result_valid       = 1'b1;
               result.result_kind = KIND_LEN_ERR;
            end else begin
               phase_in = PH_INSTR;
            end
         end
         PH_INSTR: begin
            instr_in = item_byte;
            crc_in   = crc_next;
            count_in = '0;
            phase_in = (length_ff == MIN_BODY_LENGTH) ? PH_CRCLO : PH_PARAM;
         end
         PH_PARAM: begin
            crc_in                  = crc_next;
            result_valid            = 1'b1;
            result.result_kind      = KIND_PARAM;
            result.param_byte       = item_byte;
            result.param_index      = count_ff;
            result.instruction_code = instr_ff;
            result.param_count      = pcount;
            count_in                = count_ff + 16'd1;
            if (count_in >= pcount) begin
               phase_in = PH_CRCLO;
            end
         end
         PH_CRCLO: begin
            crc_low_in = item_byte;
            phase_in   = PH_CRCHI;
         end
         PH_CRCHI: begin
            phase_in                = PH_HUNT0;
            result_valid            = 1'b1;
            result.result_kind      = ({item_byte, crc_low_ff} == crc_ff) ? KIND_GOOD
                                                                          : KIND_CRC_ERR;
            result.instruction_code = instr_ff;
            result.param_count      = pcount;
         end
         default: begin
            phase_in = (item_byte == HDR_BYTE_FF) ? PH_HUNT1 : PH_HUNT0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT0;
         id_ff      <= '0;
         length_ff  <= '0;
         count_ff   <= '0;
         instr_ff   <= '0;
         crc_ff     <= '0;
         crc_low_ff <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         id_ff      <= id_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         instr_ff   <= instr_in;
         crc_ff     <= crc_in;
         crc_low_ff <= crc_low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_PACKET_RESET;
      end else if (csr_write_enable) begin
         max_bytes_ff <= csr_write_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/spd_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module spd_out_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                result_valid,
   input  wire spd_pkg::result_type result,
   output logic                     out_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output spd_pkg::result_type      rsp_result
);
   import spd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // a held transaction frees the register in the cycle it is taken
   assign out_ready = !valid_ff || !rsp_stall;
   assign valid_in  = out_ready ? result_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && result_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

>>> dv/servo_packet_deframer_crc16_checker.sv
`timescale 1ns / 1ps

package spd_tb_pkg;
   import spd_pkg::CRC_POLY;

   // bit-serial form of the msb-first crc-16
   function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ data[i];
         c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

endpackage

module servo_packet_deframer_crc16_checker
   import spd_pkg::*;
   import spd_tb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [1:0]  rsp_result_kind,
   input  wire logic [7:0]  rsp_param_byte,
   input  wire logic [15:0] rsp_param_index,
   input  wire logic [7:0]  rsp_packet_id,
   input  wire logic [7:0]  rsp_instruction_code,
   input  wire logic [15:0] rsp_param_count,
   output int               fail_count,
   output int               pending,
   output int               params_seen,
   output int               good_seen,
   output int               crc_err_seen,
   output int               len_err_seen
);

   result_type  expected_results[$];
   result_type  want;
   phase_type   phase;
   logic [15:0] max_bytes;
   logic [15:0] body_len;
   logic [15:0] param_idx;
   logic [15:0] crc_acc;
   logic [7:0]  pkt_id;
   logic [7:0]  pkt_instr;
   logic [7:0]  crc_lo;

   task automatic deframe_byte(input logic [7:0] b);
      result_type  r;
      logic [15:0] n_param;
      r       = '0;
      n_param = body_len - MIN_BODY_LENGTH;
      case (phase)
         PH_HUNT1: begin
            phase = (b == HDR_BYTE_FF) ? PH_HUNT2 : PH_HUNT0;
         end
         PH_HUNT2: begin
            // an extra FF keeps the hunt where it is
            if (b == HDR_BYTE_FD) begin
               phase = PH_HUNT3;
            end else if (b != HDR_BYTE_FF) begin
               phase = PH_HUNT0;
            end
         end
         PH_HUNT3: begin
            if (b == HDR_BYTE_00) begin
               crc_acc = crc16_next(crc16_next(crc16_next(crc16_next(16'h0000, HDR_BYTE_FF),
                                    HDR_BYTE_FF), HDR_BYTE_FD), HDR_BYTE_00);
               phase   = PH_ID;
            end else begin
               phase = PH_HUNT0;
            end
         end
         PH_ID: begin
            pkt_id  = b;
            crc_acc = crc16_next(crc_acc, b);
            phase   = PH_LENLO;
         end
         PH_LENLO: begin
            body_len = {8'h00, b};
            crc_acc  = crc16_next(crc_acc, b);
            phase    = PH_LENHI;
         end
         PH_LENHI: begin
            body_len = {b, body_len[7:0]};
            crc_acc  = crc16_next(crc_acc, b);
            if (body_len < MIN_BODY_LENGTH ||
                ({1'b0, body_len} + FRAME_OVERHEAD) > {1'b0, max_bytes}) begin
               r.result_kind = KIND_LEN_ERR;
               r.packet_id   = pkt_id;
               expected_results.push_back(r);
               phase = PH_HUNT0;
            end else begin
               phase = PH_INSTR;
            end
         end
         PH_INSTR: begin
            pkt_instr = b;
            crc_acc   = crc16_next(crc_acc, b);
            param_idx = '0;
            phase     = (body_len == MIN_BODY_LENGTH) ? PH_CRCLO : PH_PARAM;
         end
         PH_PARAM: begin
            crc_acc = crc16_next(crc_acc, b);
            r.result_kind      = KIND_PARAM;
            r.param_byte       = b;
            r.param_index      = param_idx;
            r.packet_id        = pkt_id;
            r.instruction_code = pkt_instr;
            r.param_count      = n_param;
            expected_results.push_back(r);
            param_idx = param_idx + 16'd1;
            if (param_idx >= n_param) begin
               phase = PH_CRCLO;
            end
         end
         PH_CRCLO: begin
            crc_lo = b;
            phase  = PH_CRCHI;
         end
         PH_CRCHI: begin
            r.result_kind      = ({b, crc_lo} == crc_acc) ? KIND_GOOD : KIND_CRC_ERR;
            r.packet_id        = pkt_id;
            r.instruction_code = pkt_instr;
            r.param_count      = n_param;
            expected_results.push_back(r);
            phase = PH_HUNT0;
         end
         default: begin
            phase = (b == HDR_BYTE_FF) ? PH_HUNT1 : PH_HUNT0;
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_val,
                              input logic [15:0] act_val);
      if (act_val !== exp_val) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         phase        = PH_HUNT0;
         max_bytes    = MAX_PACKET_RESET;
         body_len     = '0;
         param_idx    = '0;
         crc_acc      = '0;
         pkt_id       = '0;
         pkt_instr    = '0;
         crc_lo       = '0;
         fail_count   = 0;
         pending      = 0;
         params_seen  = 0;
         good_seen    = 0;
         crc_err_seen = 0;
         len_err_seen = 0;
      end else begin
         if (csr_write_enable) begin
            max_bytes = csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            case (rsp_result_kind)
               KIND_PARAM:   params_seen++;
               KIND_GOOD:    good_seen++;
               KIND_CRC_ERR: crc_err_seen++;
               default:      len_err_seen++;
            endcase
            if (expected_results.size() == 0) begin
               fail_count++;
               $display("%0t: result transaction, expected none, actual kind %0d id %0h",
                        $time, rsp_result_kind, rsp_packet_id);
            end else begin
               want = expected_results.pop_front();
               check_field("result_kind", 16'(want.result_kind), 16'(rsp_result_kind));
               check_field("param_byte", 16'(want.param_byte), 16'(rsp_param_byte));
               check_field("param_index", want.param_index, rsp_param_index);
               check_field("packet_id", 16'(want.packet_id), 16'(rsp_packet_id));
               check_field("instruction_code", 16'(want.instruction_code),
                           16'(rsp_instruction_code));
               check_field("param_count", want.param_count, rsp_param_count);
            end
         end
         if (req_valid && !req_stall) begin
            deframe_byte(req_rx_byte);
         end
         pending = expected_results.size();
      end
   end

endmodule

>>> dv/tb_servo_packet_deframer_crc16_unit.sv
`timescale 1ns / 1ps

module tb_servo_packet_deframer_crc16_unit;
   import spd_pkg::*;
   import spd_tb_pkg::*;

   typedef enum int {
      PKT_GOOD,
      PKT_CRC_BAD,
      PKT_LEN_BAD,
      PKT_CUT,
      PKT_NOISE
   } pkt_style_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;
   logic        req_valid;
   wire logic   req_stall;
   logic [7:0]  req_rx_byte;
   wire logic   rsp_valid;
   logic        rsp_stall;
   wire logic [1:0]  rsp_result_kind;
   wire logic [7:0]  rsp_param_byte;
   wire logic [15:0] rsp_param_index;
   wire logic [7:0]  rsp_packet_id;
   wire logic [7:0]  rsp_instruction_code;
   wire logic [15:0] rsp_param_count;

   int          fail_count;
   int          pending;
   int          params_seen;
   int          good_seen;
   int          crc_err_seen;
   int          len_err_seen;
   logic        steady;
   int          bytes_sent;
   int          packets_sent;
   int          settings_used;
   logic [15:0] max_now;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 18);
      end
   end

   servo_packet_deframer_crc16_unit i_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_param_byte       (rsp_param_byte),
      .rsp_param_index      (rsp_param_index),
      .rsp_packet_id        (rsp_packet_id),
      .rsp_instruction_code (rsp_instruction_code),
      .rsp_param_count      (rsp_param_count)
   );

   servo_packet_deframer_crc16_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_param_byte       (rsp_param_byte),
      .rsp_param_index      (rsp_param_index),
      .rsp_packet_id        (rsp_packet_id),
      .rsp_instruction_code (rsp_instruction_code),
      .rsp_param_count      (rsp_param_count),
      .fail_count           (fail_count),
      .pending              (pending),
      .params_seen          (params_seen),
      .good_seen            (good_seen),
      .crc_err_seen         (crc_err_seen),
      .len_err_seen         (len_err_seen)
   );

   // returns once the byte's transaction has been taken
   task automatic send_byte(input logic [7:0] b);
      while (!steady && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   task automatic send_tracked(input logic [7:0] b, inout logic [15:0] crc);
      send_byte(b);
      crc = crc16_next(crc, b);
   endtask

   // sender holds off until every result is in and the pipe has emptied
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic set_max(input logic [15:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      max_now = v;
      settings_used++;
   endtask

   task automatic send_packet(input pkt_style_type style, input int n_param,
                              input logic [7:0] id, input logic [7:0] instr);
      logic [7:0]  hdr [4];
      logic [15:0] crc;
      logic [15:0] len;
      int          keep;
      hdr[0] = HDR_BYTE_FF;
      hdr[1] = HDR_BYTE_FF;
      hdr[2] = HDR_BYTE_FD;
      hdr[3] = HDR_BYTE_00;
      crc    = 16'h0000;
      packets_sent++;
      if (style == PKT_NOISE) begin
         repeat ($urandom_range(1, 8)) begin
            send_byte(($urandom_range(2) == 0) ? HDR_BYTE_FF : 8'($urandom));
         end
      end else if (style == PKT_CUT) begin
         keep = $urandom_range(1, 3);
         for (int k = 0; k < keep; k++) begin
            send_byte(hdr[k]);
         end
         send_byte(8'($urandom));
      end else begin
         for (int k = 0; k < 4; k++) begin
            send_tracked(hdr[k], crc);
         end
         send_tracked(id, crc);
         if (style == PKT_LEN_BAD) begin
            if ($urandom_range(1) == 0) begin
               len = 16'($urandom_range(0, 2));
            end else if (max_now < 16'd10) begin
               len = 16'($urandom);
            end else begin
               // smallest length whose whole packet exceeds the maximum, and up
               len = 16'($urandom_range(int'(max_now) - 6, 65535));
            end
         end else begin
            len = 16'(n_param + 3);
         end
         send_tracked(len[7:0], crc);
         send_tracked(len[15:8], crc);
         if (style != PKT_LEN_BAD) begin
            send_tracked(instr, crc);
            repeat (n_param) begin
               send_tracked(8'($urandom), crc);
            end
            if (style == PKT_CRC_BAD) begin
               crc ^= 16'(1) << $urandom_range(15);
            end
            send_byte(crc[7:0]);
            send_byte(crc[15:8]);
         end
      end
   endtask

   task automatic run_phase(input logic [15:0] max_bytes, input int budget);
      int stop;
      int pick;
      int n;
      set_max(max_bytes);
      if (max_bytes == 16'hFFFF) begin
         send_packet(PKT_GOOD, 300, 8'($urandom), 8'($urandom));
      end
      stop = bytes_sent + budget;
      while (bytes_sent < stop) begin
         pick = $urandom_range(99);
         n = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
         if (max_now >= 16'd10 && n > int'(max_now) - 10) begin
            n = int'(max_now) - 10;
         end
         // stray FF ahead of the header
         if ($urandom_range(7) == 0) begin
            send_byte(HDR_BYTE_FF);
         end
         if (pick < 60) begin
            send_packet(PKT_GOOD, n, 8'($urandom), 8'($urandom));
         end else if (pick < 72) begin
            send_packet(PKT_CRC_BAD, n, 8'($urandom), 8'($urandom));
         end else if (pick < 82) begin
            send_packet(PKT_LEN_BAD, n, 8'($urandom), 8'($urandom));
         end else if (pick < 90) begin
            send_packet(PKT_CUT, n, 8'($urandom), 8'($urandom));
         end else begin
            send_packet(PKT_NOISE, n, 8'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 16'h0000;
      req_valid        <= 1'b0;
      req_rx_byte      <= 8'h00;
      rsp_stall        <= 1'b0;
      steady        = 1'b0;
      bytes_sent    = 0;
      packets_sent  = 0;
      settings_used = 0;
      max_now       = MAX_PACKET_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero while hunting, then FF FF FF FD 00 with a zero length
      send_byte(HDR_BYTE_00);
      send_byte(HDR_BYTE_FF);
      send_byte(HDR_BYTE_FF);
      send_byte(HDR_BYTE_FF);
      send_byte(HDR_BYTE_FD);
      send_byte(HDR_BYTE_00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      // bad second header byte, then FF where the trailing zero belongs
      send_byte(HDR_BYTE_FF);
      send_byte(8'h5A);
      send_byte(HDR_BYTE_FF);
      send_byte(HDR_BYTE_FF);
      send_byte(HDR_BYTE_FD);
      send_byte(HDR_BYTE_FF);
      // shortest legal packet
      send_packet(PKT_GOOD, 0, 8'hFF, 8'h00);

      run_phase(MAX_PACKET_RESET, 220);
      run_phase(16'd10, 180);
      run_phase(16'd9, 80);
      steady = 1'b1;
      run_phase(16'hFFFF, 200);
      steady = 1'b0;
      run_phase(16'd0, 60);
      run_phase(16'($urandom_range(11, 120)), 220);
      run_phase(16'($urandom_range(121, 65534)), 220);
      run_phase(MAX_PACKET_RESET, 180);

      drain();
      repeat (6) @(posedge clock);
      $display("Sent %0d bytes as %0d packets or fragments under %0d maximum-size settings",
               bytes_sent, packets_sent, settings_used);
      $display("Results: %0d parameter, %0d good, %0d crc error, %0d length error",
               params_seen, good_seen, crc_err_seen, len_err_seen);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> files.f
rtl/spd_pkg.sv
rtl/spd_in_stage.sv
rtl/spd_deframe_core.sv
rtl/spd_out_stage.sv
rtl/servo_packet_deframer_crc16_unit.sv
dv/servo_packet_deframer_crc16_checker.sv
dv/tb_servo_packet_deframer_crc16_unit.sv
